// File: design/snz_pkg.sv
// Shared types, constants and helper functions of the simplex noise block.
`timescale 1ns / 1ps
package snz_pkg;

    localparam int TBL_BITS  = 8;
    localparam int TBL_SIZE  = 1 << TBL_BITS;
    localparam int FRAC_BITS = 16;
    localparam int MAX_OCT   = 8;
    localparam int CRD_W     = 40;  // scaled coordinate width
    localparam int DIV_W     = 44;  // operand width of the divide-by-3 unit
    localparam int CELL_W    = 28;  // cell index width
    localparam int OFS_W     = 32;  // corner offsets and products
    localparam int ACC_W     = 40;
    localparam int OUT_W     = 20;

    localparam logic signed [OFS_W-1:0] FX_ONE    = OFS_W'(1 << FRAC_BITS);
    localparam logic signed [OFS_W-1:0] FX_G1     = OFS_W'(((1 << FRAC_BITS) + 3) / 6);
    localparam logic signed [OFS_W-1:0] FX_G2     = OFS_W'((2 * (1 << FRAC_BITS) + 3) / 6);
    localparam logic signed [OFS_W-1:0] FX_G3     = OFS_W'((1 << FRAC_BITS) / 2);
    localparam logic signed [OFS_W-1:0] FX_POINT6 = OFS_W'((6 * (1 << FRAC_BITS) + 5) / 10);

    localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(524287);
    localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(524288);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_TURB   = 2'd1;
    localparam logic [1:0] MODE_FBM    = 2'd2;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef struct packed {
        logic                en;
        logic [TBL_BITS-1:0] addr;
        logic [7:0]          data;
    } snz_tbl_wr_t;

    typedef struct packed {
        logic             done;
        logic [OFS_W-1:0] noise;
    } snz_eval_st_t;

    // Hash byte modulo 12 by a reciprocal multiply; exact for all bytes.
    function automatic logic [3:0] snz_mod12(input logic [7:0] h);
        logic [15:0] p;
        logic [7:0]  q;
        logic [7:0]  r;
        p = 16'(h) * 16'd171;
        q = 8'(p >> 11);
        r = h - 8'(q * 8'd12);
        return r[3:0];
    endfunction

    // Edge gradient of a hash as three 2-bit signed components {gx, gy, gz}.
    function automatic logic [5:0] snz_grad(input logic [7:0] h);
        logic [5:0] g;
        case (snz_mod12(h))
            4'd0:    g = {2'sd1,  2'sd1,  2'sd0};
            4'd1:    g = {-2'sd1, 2'sd1,  2'sd0};
            4'd2:    g = {2'sd1,  -2'sd1, 2'sd0};
            4'd3:    g = {-2'sd1, -2'sd1, 2'sd0};
            4'd4:    g = {2'sd1,  2'sd0,  2'sd1};
            4'd5:    g = {-2'sd1, 2'sd0,  2'sd1};
            4'd6:    g = {2'sd1,  2'sd0,  -2'sd1};
            4'd7:    g = {-2'sd1, 2'sd0,  -2'sd1};
            4'd8:    g = {2'sd0,  2'sd1,  2'sd1};
            4'd9:    g = {2'sd0,  -2'sd1, 2'sd1};
            4'd10:   g = {2'sd0,  2'sd1,  -2'sd1};
            4'd11:   g = {2'sd0,  -2'sd1, -2'sd1};
            default: g = 6'd0;
        endcase
        return g;
    endfunction

    // One gradient component times an offset.
    function automatic logic signed [OFS_W-1:0] snz_term(input logic [1:0] g,
                                                        input logic signed [OFS_W-1:0] c);
        logic signed [OFS_W-1:0] r;
        case (g)
            2'b01:   r = c;
            2'b11:   r = -c;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: design/simplex_noise_3d.sv
// Top level of the 3D simplex noise block: handshakes, octave loop, output register.
//
// Input channel (s_valid/s_ready): a load transaction (command 0) writes one
// permutation table byte and yields no result. An evaluate transaction
// (command 1) yields one noise_value on the m_ channel, and must follow
// loads of every table entry it can touch.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) set the octave mode
// and octave count; write them only while the block is idle.
// Each octave runs a launch step, two passes of the divide-by-3 unit for the
// skew and unskew, a ranking step, then per corner a pass on the shared
// multiplier and the single table read port, which skips the falloff products
// for a corner outside the falloff radius, then a finish and a hand-back step.
// Single mode runs one octave, turbulence two, Brownian motion up to eight;
// with zero octaves no evaluation runs. s_ready stays low from the accept
// until the result goes to the output register.
// The result sits in an output register; a new transaction is accepted while
// it waits, and a finished evaluation holds until the register is free.
// Reset clears the handshake state and the registers (mode 0, count 4); the
// permutation table is not cleared.
`timescale 1ns / 1ps
module simplex_noise_3d import snz_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic                    cfg_index,
    input  logic [3:0]              cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_command,
    input  logic [7:0]              s_table_index,
    input  logic [7:0]              s_table_value,
    input  logic signed [31:0]      s_coord_x,
    input  logic signed [31:0]      s_coord_y,
    input  logic signed [31:0]      s_coord_z,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_noise_value
);

    typedef enum logic [1:0] {T_IDLE, T_LAUNCH, T_WAIT, T_HOLD} state_t;

    state_t state_reg;
    logic [1:0] mode_reg;
    logic [3:0] count_reg;
    logic [3:0] oct_reg, n_reg;
    logic       turb_reg;
    logic signed [31:0]      x_reg, y_reg, z_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    m_valid_reg;
    logic signed [OUT_W-1:0] m_noise_reg;

    logic         accept;
    logic [3:0]   n_next;
    snz_tbl_wr_t  tbl_wr;
    snz_eval_st_t ev_st;
    logic         ev_start;
    logic signed [CRD_W-1:0] sx, sy, sz;
    logic signed [ACC_W-1:0] acc_next, sat;

    function automatic logic signed [CRD_W-1:0] scale(input logic signed [31:0] v,
                                                      input logic [2:0] o,
                                                      input logic triple);
        logic signed [CRD_W-1:0] e;
        e = CRD_W'(v);
        return triple ? (e + (e <<< 1)) : (e <<< o);
    endfunction

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == T_IDLE);

    always_comb begin
        case (mode_reg)
            MODE_TURB: n_next = 4'd2;
            MODE_FBM:  n_next = (count_reg > 4'(MAX_OCT)) ? 4'(MAX_OCT) : count_reg;
            default:   n_next = 4'd1;
        endcase
    end

    assign tbl_wr.en   = accept && (s_command == CMD_LOAD);
    assign tbl_wr.addr = s_table_index[TBL_BITS-1:0];
    assign tbl_wr.data = s_table_value;

    // Turbulence uses a factor of three for its second octave.
    assign sx = scale(x_reg, oct_reg[2:0], turb_reg && oct_reg[0]);
    assign sy = scale(y_reg, oct_reg[2:0], turb_reg && oct_reg[0]);
    assign sz = scale(z_reg, oct_reg[2:0], turb_reg && oct_reg[0]);
    assign ev_start = (state_reg == T_LAUNCH);

    snz_eval u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tbl_wr  (tbl_wr),
        .start   (ev_start),
        .px      (sx),
        .py      (sy),
        .pz      (sz),
        .status  (ev_st)
    );

    assign acc_next = acc_reg + (ACC_W'($signed(ev_st.noise)) >>> oct_reg[2:0]);

    always_comb begin
        if (acc_reg > OUT_MAX) begin
            sat = OUT_MAX;
        end else if (acc_reg < OUT_MIN) begin
            sat = OUT_MIN;
        end else begin
            sat = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            mode_reg    <= MODE_SINGLE;
            count_reg   <= 4'd4;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_MODE) begin
                    mode_reg <= cfg_data[1:0];
                end else begin
                    count_reg <= cfg_data;
                end
            end
            if (state_reg == T_HOLD && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE: begin
                    if (accept && s_command == CMD_EVAL) begin
                        x_reg     <= s_coord_x;
                        y_reg     <= s_coord_y;
                        z_reg     <= s_coord_z;
                        n_reg     <= n_next;
                        turb_reg  <= (mode_reg == MODE_TURB);
                        oct_reg   <= '0;
                        acc_reg   <= '0;
                        state_reg <= (n_next == '0) ? T_HOLD : T_LAUNCH;
                    end
                end
                T_LAUNCH: state_reg <= T_WAIT;
                T_WAIT: begin
                    if (ev_st.done) begin
                        acc_reg <= acc_next;
                        oct_reg <= oct_reg + 1'b1;
                        state_reg <= (oct_reg + 1'b1 == n_reg) ? T_HOLD : T_LAUNCH;
                    end
                end
                T_HOLD: begin
                    if (!m_valid_reg || m_ready) begin
                        m_noise_reg <= sat[OUT_W-1:0];
                        state_reg   <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_noise_value = m_noise_reg;

endmodule

// File: design/snz_div3.sv
// Signed floor division by three, one 16-bit digit per cycle by reciprocal multiply.
`timescale 1ns / 1ps
module snz_div3 import snz_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [DIV_W-1:0] dividend,
    output logic                    done,
    output logic signed [DIV_W-1:0] quotient
);

    localparam int U_W    = 48;
    localparam int DIG_W  = 16;
    localparam int N_DIG  = U_W / DIG_W;
    localparam int CNT_W  = $clog2(N_DIG + 1);
    localparam int V_W    = DIG_W + 2;
    localparam int RCP_SH = DIG_W + 3;
    localparam int P_W    = V_W + RCP_SH;
    localparam logic [RCP_SH-1:0] RCP = RCP_SH'(((1 << RCP_SH) + 2) / 3);

    logic [U_W-1:0]   u_reg;
    logic [1:0]       rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [V_W-1:0]   v;
    logic [P_W-1:0]   prod;
    logic [DIG_W-1:0] qd;
    logic [V_W-1:0]   back;

    // Each step divides the running remainder and the next digit by three.
    // The rounded-up reciprocal is exact for every value below 3 * 2^16.
    assign v    = {rem_reg, u_reg[U_W-1 -: DIG_W]};
    assign prod = P_W'(v) * P_W'(RCP);
    assign qd   = prod[RCP_SH +: DIG_W];
    assign back = V_W'(qd) + (V_W'(qd) << 1);

    // A bias of three times 2^DIV_W makes the dividend positive; the low
    // quotient bits are then the floored signed result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                u_reg   <= U_W'($signed(dividend)) + (U_W'(3) << DIV_W);
                rem_reg <= '0;
                cnt_reg <= CNT_W'(N_DIG);
            end else if (cnt_reg != '0) begin
                u_reg   <= {u_reg[U_W-DIG_W-1:0], qd};
                rem_reg <= 2'(v - back);
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = u_reg[DIV_W-1:0];

endmodule

// File: design/snz_eval.sv
// Single-octave noise evaluation: skew, ranking, hashing and corner sums.
`timescale 1ns / 1ps
module snz_eval import snz_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  snz_tbl_wr_t             tbl_wr,
    input  logic                    start,
    input  logic signed [CRD_W-1:0] px,
    input  logic signed [CRD_W-1:0] py,
    input  logic signed [CRD_W-1:0] pz,
    output snz_eval_st_t            status
);

    typedef enum logic [3:0] {
        E_IDLE, E_DIVS, E_DIVT, E_RANK, E_CSET, E_H1, E_H2, E_H3,
        E_M4, E_M5, E_M6, E_M7, E_M8, E_CNEXT, E_FIN
    } state_t;

    localparam int W = 48;

    state_t state_reg;

    logic [7:0] mem [TBL_SIZE];
    logic [7:0] mem_q;
    logic [TBL_BITS-1:0] rd_addr;

    logic signed [CRD_W-1:0]  x_reg, y_reg, z_reg;
    logic signed [CELL_W-1:0] i_reg, j_reg, k_reg;
    logic signed [OFS_W-1:0]  x0_reg, y0_reg, z0_reg;
    logic signed [OFS_W-1:0]  cx_reg, cy_reg, cz_reg;
    logic signed [OFS_W-1:0]  t_reg, sum_reg;
    logic [2:0]  off1_reg, off2_reg, off_reg;
    logic [1:0]  corner_reg;
    logic [5:0]  grad_reg;
    logic signed [63:0] p_reg;
    logic        done_reg;

    logic signed [OFS_W-1:0] mul_a, mul_b, prod, dot, t_new;
    logic                    div_start, div_done;
    logic signed [DIV_W-1:0] div_v, div_q;
    logic signed [W-1:0]     xs, ys, zs, ijk, t_w;
    logic signed [CELL_W-1:0] i_n, j_n, k_n;
    logic [2:0]              off_sel;
    logic signed [OFS_W-1:0] g_sel;

    snz_div3 u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_v),
        .done     (div_done),
        .quotient (div_q)
    );

    assign prod = p_reg[FRAC_BITS+OFS_W-1:FRAC_BITS];

    // Cell indexes from the skew factor s, which the divider returns in E_DIVS.
    always_comb begin
        xs  = W'(x_reg) + W'(div_q);
        ys  = W'(y_reg) + W'(div_q);
        zs  = W'(z_reg) + W'(div_q);
        i_n = xs[FRAC_BITS+CELL_W-1:FRAC_BITS];
        j_n = ys[FRAC_BITS+CELL_W-1:FRAC_BITS];
        k_n = zs[FRAC_BITS+CELL_W-1:FRAC_BITS];
        ijk = W'(i_n) + W'(j_n) + W'(k_n);
        t_w = W'(div_q);
    end

    always_comb begin
        div_start = 1'b0;
        div_v     = '0;
        if (state_reg == E_IDLE && start) begin
            div_start = 1'b1;
            div_v     = DIV_W'(W'(px) + W'(py) + W'(pz));
        end else if (state_reg == E_DIVS && div_done) begin
            div_start = 1'b1;
            div_v     = DIV_W'(ijk <<< (FRAC_BITS - 1));
        end
    end

    always_comb begin
        case (corner_reg)
            2'd0:    begin off_sel = 3'b000;   g_sel = '0;    end
            2'd1:    begin off_sel = off1_reg; g_sel = FX_G1; end
            2'd2:    begin off_sel = off2_reg; g_sel = FX_G2; end
            default: begin off_sel = 3'b111;   g_sel = FX_G3; end
        endcase
    end

    assign dot = snz_term(grad_reg[5:4], cx_reg) + snz_term(grad_reg[3:2], cy_reg)
               + snz_term(grad_reg[1:0], cz_reg);
    assign t_new = t_reg - prod;

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        rd_addr = k_reg[TBL_BITS-1:0] + TBL_BITS'(off_sel[0]);
        case (state_reg)
            E_H1: begin
                mul_a   = cx_reg;
                mul_b   = cx_reg;
                rd_addr = j_reg[TBL_BITS-1:0] + TBL_BITS'(off_reg[1]) + mem_q;
            end
            E_H2: begin
                mul_a   = cy_reg;
                mul_b   = cy_reg;
                rd_addr = i_reg[TBL_BITS-1:0] + TBL_BITS'(off_reg[2]) + mem_q;
            end
            E_H3: begin
                mul_a = cz_reg;
                mul_b = cz_reg;
            end
            E_M5: begin
                mul_a = t_reg;
                mul_b = t_reg;
            end
            E_M6: begin
                mul_a = prod;
                mul_b = prod;
            end
            E_M7: begin
                mul_a = prod;
                mul_b = dot;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tbl_wr.en) begin
            mem[tbl_wr.addr] <= tbl_wr.data;
        end
        mem_q <= mem[rd_addr];
        p_reg <= mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                E_IDLE: begin
                    if (start) begin
                        x_reg     <= px;
                        y_reg     <= py;
                        z_reg     <= pz;
                        state_reg <= E_DIVS;
                    end
                end
                E_DIVS: begin
                    if (div_done) begin
                        i_reg     <= i_n;
                        j_reg     <= j_n;
                        k_reg     <= k_n;
                        state_reg <= E_DIVT;
                    end
                end
                E_DIVT: begin
                    if (div_done) begin
                        x0_reg    <= OFS_W'(W'(x_reg) - (W'(i_reg) <<< FRAC_BITS) + t_w);
                        y0_reg    <= OFS_W'(W'(y_reg) - (W'(j_reg) <<< FRAC_BITS) + t_w);
                        z0_reg    <= OFS_W'(W'(z_reg) - (W'(k_reg) <<< FRAC_BITS) + t_w);
                        state_reg <= E_RANK;
                    end
                end
                E_RANK: begin
                    // Rank the offsets to pick the tetrahedron's middle corners.
                    if (x0_reg >= y0_reg) begin
                        if (y0_reg >= z0_reg) begin
                            off1_reg <= 3'b100; off2_reg <= 3'b110;
                        end else if (x0_reg >= z0_reg) begin
                            off1_reg <= 3'b100; off2_reg <= 3'b101;
                        end else begin
                            off1_reg <= 3'b001; off2_reg <= 3'b101;
                        end
                    end else begin
                        if (y0_reg < z0_reg) begin
                            off1_reg <= 3'b001; off2_reg <= 3'b011;
                        end else if (x0_reg < z0_reg) begin
                            off1_reg <= 3'b010; off2_reg <= 3'b011;
                        end else begin
                            off1_reg <= 3'b010; off2_reg <= 3'b110;
                        end
                    end
                    corner_reg <= '0;
                    sum_reg    <= '0;
                    state_reg  <= E_CSET;
                end
                E_CSET: begin
                    cx_reg    <= x0_reg - (off_sel[2] ? FX_ONE : '0) + g_sel;
                    cy_reg    <= y0_reg - (off_sel[1] ? FX_ONE : '0) + g_sel;
                    cz_reg    <= z0_reg - (off_sel[0] ? FX_ONE : '0) + g_sel;
                    off_reg   <= off_sel;
                    state_reg <= E_H1;
                end
                E_H1: state_reg <= E_H2;
                E_H2: begin
                    t_reg     <= FX_POINT6 - prod;
                    state_reg <= E_H3;
                end
                E_H3: begin
                    t_reg     <= t_new;
                    grad_reg  <= snz_grad(mem_q);
                    state_reg <= E_M4;
                end
                E_M4: begin
                    // A corner outside the falloff radius adds nothing.
                    t_reg     <= t_new;
                    state_reg <= t_new[OFS_W-1] ? E_CNEXT : E_M5;
                end
                E_M5: state_reg <= E_M6;
                E_M6: state_reg <= E_M7;
                E_M7: state_reg <= E_M8;
                E_M8: begin
                    sum_reg   <= sum_reg + prod;
                    state_reg <= E_CNEXT;
                end
                E_CNEXT: begin
                    corner_reg <= corner_reg + 1'b1;
                    state_reg  <= (corner_reg == 2'd3) ? E_FIN : E_CSET;
                end
                E_FIN: begin
                    done_reg  <= 1'b1;
                    state_reg <= E_IDLE;
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    assign status.done  = done_reg;
    assign status.noise = sum_reg <<< 5;

endmodule

// File: design/snz_checker.sv
// Port-level assertions for the simplex noise block and their bind.
`timescale 1ns / 1ps
module snz_checker import snz_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    s_command,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [OUT_W-1:0] m_noise_value
);

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A stalled result stays offered with the same value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_noise_value))
        else $error("stalled result dropped or changed");

    // An evaluate transaction occupies the block on the next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == CMD_EVAL |=> !s_ready)
        else $error("input ready right after an evaluate");

    // A load transaction never produces a result.
    a_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == CMD_LOAD && !m_valid |=> !m_valid)
        else $error("result appeared after a load");

endmodule

bind simplex_noise_3d snz_checker u_snz_checker (.*);
